// ===== sv/feeder_access_sequencer_top_defines.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef FEEDER_ACCESS_SEQUENCER_TOP_DEFINES_SVH
`define FEEDER_ACCESS_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fas_pkg.sv =====
`timescale 1ns / 1ps

package fas_pkg;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DETECT = 5'b00010,
        ST_OPEN   = 5'b00100,
        ST_FEED   = 5'b01000,
        ST_CLOSE  = 5'b10000
    } state_t;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PHASE_IDLE   = 3'd0;
    localparam logic [2:0] PHASE_DETECT = 3'd1;
    localparam logic [2:0] PHASE_OPEN   = 3'd2;
    localparam logic [2:0] PHASE_FEED   = 3'd3;
    localparam logic [2:0] PHASE_CLOSE  = 3'd4;

    // Motor commands
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_HOME    = 2'd2;
    localparam logic [1:0] CMD_DISABLE = 2'd3;

    // Fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OPEN  = 2'd1;
    localparam logic [1:0] FAULT_CLOSE = 2'd2;

    // Register map
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_DETECT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MOTOR_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_LEAVE_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_MAX_MEAL       = 2'd3;

    localparam logic [31:0] DETECT_TIMEOUT_RST = 32'd5000;
    localparam logic [31:0] MOTOR_TIMEOUT_RST  = 32'd10000;
    localparam logic [31:0] LEAVE_TIMEOUT_RST  = 32'd3000;
    localparam logic [31:0] MAX_MEAL_RST       = 32'd600000;

    localparam logic [16:0] INTAKE_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               animal_present;
        logic               tag_seen;
        logic               tag_matched;
        logic [3:0]         profile_index;
        logic [15:0]        bowl_position;
        logic [1:0]         bowl_number;
        logic               motor_arrived;
        logic signed [17:0] weight_dg;
        logic               weight_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  motor_command;
        logic [15:0] motor_target;
        logic [1:0]  active_bowl;
        logic [1:0]  fault_code;
        logic        motor_healthy;
        logic        record_emit;
        logic [3:0]  record_profile;
        logic [31:0] record_start_ms;
        logic [16:0] record_intake_dg;
        logic        record_intake_ok;
    } out_item_t;

    typedef struct packed {
        logic [31:0] detect_timeout_ms;
        logic [31:0] motor_move_limit_ms;
        logic [31:0] leave_timeout_ms;
        logic [31:0] max_meal_ms;
    } cfg_t;

endpackage

// ===== sv/fas_if.sv =====
`timescale 1ns / 1ps

// Control-loop pass channel
interface fas_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               animal_present;
    logic               tag_seen;
    logic               tag_matched;
    logic [3:0]         profile_index;
    logic [15:0]        bowl_position;
    logic [1:0]         bowl_number;
    logic               motor_arrived;
    logic signed [17:0] weight_dg;
    logic               weight_ok;

    modport source (
        output valid, now_ms, animal_present, tag_seen, tag_matched, profile_index,
               bowl_position, bowl_number, motor_arrived, weight_dg, weight_ok,
        input  ready
    );
    modport sink (
        input  valid, now_ms, animal_present, tag_seen, tag_matched, profile_index,
               bowl_position, bowl_number, motor_arrived, weight_dg, weight_ok,
        output ready
    );
endinterface

// Sequencer result channel
interface fas_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic [1:0]  motor_command;
    logic [15:0] motor_target;
    logic [1:0]  active_bowl;
    logic [1:0]  fault_code;
    logic        motor_healthy;
    logic        record_emit;
    logic [3:0]  record_profile;
    logic [31:0] record_start_ms;
    logic [16:0] record_intake_dg;
    logic        record_intake_ok;

    modport source (
        output valid, phase, motor_command, motor_target, active_bowl, fault_code,
               motor_healthy, record_emit, record_profile, record_start_ms,
               record_intake_dg, record_intake_ok,
        input  ready
    );
    modport sink (
        input  valid, phase, motor_command, motor_target, active_bowl, fault_code,
               motor_healthy, record_emit, record_profile, record_start_ms,
               record_intake_dg, record_intake_ok,
        output ready
    );
endinterface

// ===== sv/feeder_access_sequencer_top.sv =====
`timescale 1ns / 1ps
// Channel   Modport        Transfer
// in_ch     fas_in_if      one control-loop pass (timestamp, sensors, weight)
// out_ch    fas_out_if     one result per pass (phase, motor, fault, record)
// APB       psel..prdata   timeout registers at 0x0, 0x4, 0x8, 0xC
//
// A pass is registered on input, run through the sequencer and lands in the
// result register; one pass per cycle while out_ch is not stalled.
// The result register parts the two sides; in_ch.ready drops only when both
// the input and result registers are full and out_ch is stalled.
// Reset (rst_n, asynchronous) empties both registers and restores the
// register defaults and the idle state; no clearing pass is needed.

`include "feeder_access_sequencer_top_defines.svh"

module feeder_access_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    fas_in_if.sink                          in_ch,
    fas_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fas_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    fas_pkg::cfg_t      cfg;
    fas_pkg::in_item_t  in_item;
    fas_pkg::in_item_t  in_item_reg;
    fas_pkg::out_item_t step_result;
    fas_pkg::out_item_t out_item_reg;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               in_accept;
    logic               step_fire;

    fas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fas_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (step_fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    // Gather the input payload
    always_comb
    begin
        in_item.now_ms         = in_ch.now_ms;
        in_item.animal_present = in_ch.animal_present;
        in_item.tag_seen       = in_ch.tag_seen;
        in_item.tag_matched    = in_ch.tag_matched;
        in_item.profile_index  = in_ch.profile_index;
        in_item.bowl_position  = in_ch.bowl_position;
        in_item.bowl_number    = in_ch.bowl_number;
        in_item.motor_arrived  = in_ch.motor_arrived;
        in_item.weight_dg      = in_ch.weight_dg;
        in_item.weight_ok      = in_ch.weight_ok;
    end

    // Pipeline flow control
    assign step_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step_fire;
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= in_item;
        if (step_fire)
            out_item_reg <= step_result;
    end

    // Drive the result channel
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.phase            = out_item_reg.phase;
    assign out_ch.motor_command    = out_item_reg.motor_command;
    assign out_ch.motor_target     = out_item_reg.motor_target;
    assign out_ch.active_bowl      = out_item_reg.active_bowl;
    assign out_ch.fault_code       = out_item_reg.fault_code;
    assign out_ch.motor_healthy    = out_item_reg.motor_healthy;
    assign out_ch.record_emit      = out_item_reg.record_emit;
    assign out_ch.record_profile   = out_item_reg.record_profile;
    assign out_ch.record_start_ms  = out_item_reg.record_start_ms;
    assign out_ch.record_intake_dg = out_item_reg.record_intake_dg;
    assign out_ch.record_intake_ok = out_item_reg.record_intake_ok;

    // Checks
    `FAS_ASSERT_NOW(a_record_ends_idle,
        out_valid_reg && out_item_reg.record_emit,
        out_item_reg.phase == fas_pkg::PHASE_IDLE
            && out_item_reg.motor_command == fas_pkg::CMD_DISABLE,
        "record issued without closing to idle")
    `FAS_ASSERT_NOW(a_fault_unhealthy,
        out_valid_reg && out_item_reg.fault_code != fas_pkg::FAULT_NONE,
        !out_item_reg.motor_healthy,
        "motor fault reported while motor healthy")
    `FAS_ASSERT_NOW(a_intake_ok_needs_record,
        out_valid_reg && out_item_reg.record_intake_ok,
        out_item_reg.record_emit,
        "intake flagged valid without a record")
    `FAS_ASSERT_NEXT(a_stall_holds_input,
        in_valid_reg && !step_fire,
        in_valid_reg && $stable(in_item_reg),
        "pending pass lost during output stall")

endmodule

// ===== sv/fas_cfg.sv =====
`timescale 1ns / 1ps

// Timeout register file on an APB-style port
module fas_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fas_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output fas_pkg::cfg_t                   cfg
);

    fas_pkg::cfg_t cfg_reg;
    fas_pkg::cfg_t cfg_next;
    logic [1:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                fas_pkg::REG_DETECT_TIMEOUT: cfg_next.detect_timeout_ms   = pwdata;
                fas_pkg::REG_MOTOR_TIMEOUT:  cfg_next.motor_move_limit_ms = pwdata;
                fas_pkg::REG_LEAVE_TIMEOUT:  cfg_next.leave_timeout_ms    = pwdata;
                fas_pkg::REG_MAX_MEAL:       cfg_next.max_meal_ms         = pwdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_timeout_ms   <= fas_pkg::DETECT_TIMEOUT_RST;
            cfg_reg.motor_move_limit_ms <= fas_pkg::MOTOR_TIMEOUT_RST;
            cfg_reg.leave_timeout_ms    <= fas_pkg::LEAVE_TIMEOUT_RST;
            cfg_reg.max_meal_ms         <= fas_pkg::MAX_MEAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_index)
            fas_pkg::REG_DETECT_TIMEOUT: prdata = cfg_reg.detect_timeout_ms;
            fas_pkg::REG_MOTOR_TIMEOUT:  prdata = cfg_reg.motor_move_limit_ms;
            fas_pkg::REG_LEAVE_TIMEOUT:  prdata = cfg_reg.leave_timeout_ms;
            fas_pkg::REG_MAX_MEAL:       prdata = cfg_reg.max_meal_ms;
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/fas_step.sv =====
`timescale 1ns / 1ps

// Feeder sequence state and per-pass next-state logic
module fas_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  fas_pkg::in_item_t   item,
    input  fas_pkg::cfg_t       cfg,
    output fas_pkg::out_item_t  result
);

    fas_pkg::state_t state_reg, state_next;
    logic [31:0]        entered_at_reg, entered_at_next;
    logic [31:0]        absent_since_reg, absent_since_next;
    logic               absent_timing_reg, absent_timing_next;
    logic [3:0]         profile_reg, profile_next;
    logic [1:0]         bowl_reg, bowl_next;
    logic [31:0]        meal_start_reg, meal_start_next;
    logic signed [17:0] start_weight_reg, start_weight_next;
    logic               start_weight_ok_reg, start_weight_ok_next;
    logic [16:0]        intake_reg, intake_next;
    logic               intake_ok_reg, intake_ok_next;
    logic               motor_good_reg, motor_good_next;

    logic [31:0]        since_entry;
    logic [31:0]        since_absent;
    logic               detect_expired;
    logic               motor_expired;
    logic               leave_expired;
    logic               meal_expired;
    logic signed [18:0] weight_diff;
    logic [16:0]        intake_calc;
    logic               intake_calc_ok;
    logic               close_now;
    logic [1:0]         cmd;
    logic [15:0]        target;
    logic [1:0]         fault;
    logic               emit;
    logic [2:0]         phase_code;

    // Wrapping elapsed times and limit checks
    assign since_entry    = item.now_ms - entered_at_reg;
    assign since_absent   = item.now_ms - absent_since_reg;
    assign detect_expired = since_entry > cfg.detect_timeout_ms;
    assign motor_expired  = since_entry > cfg.motor_move_limit_ms;
    assign leave_expired  = since_absent > cfg.leave_timeout_ms;
    assign meal_expired   = since_entry > cfg.max_meal_ms;

    // Intake: start minus final weight, clamped to the 17-bit range
    assign weight_diff    = {start_weight_reg[17], start_weight_reg}
                          - {item.weight_dg[17], item.weight_dg};
    assign intake_calc_ok = start_weight_ok_reg && item.weight_ok;

    always_comb
    begin
        if (!intake_calc_ok || weight_diff[18])
            intake_calc = 17'd0;
        else if (weight_diff[17])
            intake_calc = fas_pkg::INTAKE_MAX;
        else
            intake_calc = weight_diff[16:0];
    end

    // Sequencer
    always_comb
    begin
        state_next           = state_reg;
        entered_at_next      = entered_at_reg;
        absent_since_next    = absent_since_reg;
        absent_timing_next   = absent_timing_reg;
        profile_next         = profile_reg;
        bowl_next            = bowl_reg;
        meal_start_next      = meal_start_reg;
        start_weight_next    = start_weight_reg;
        start_weight_ok_next = start_weight_ok_reg;
        intake_next          = intake_reg;
        intake_ok_next       = intake_ok_reg;
        motor_good_next      = motor_good_reg;
        cmd                  = fas_pkg::CMD_NONE;
        target               = 16'd0;
        fault                = fas_pkg::FAULT_NONE;
        emit                 = 1'b0;
        close_now            = 1'b0;

        unique case (state_reg)
            fas_pkg::ST_IDLE:
            begin
                if (item.animal_present)
                begin
                    state_next      = fas_pkg::ST_DETECT;
                    entered_at_next = item.now_ms;
                end
            end
            fas_pkg::ST_DETECT:
            begin
                // timeout beats absence, absence beats the tag
                if (detect_expired || !item.animal_present)
                begin
                    state_next = fas_pkg::ST_IDLE;
                end
                else if (item.tag_seen && item.tag_matched)
                begin
                    profile_next    = item.profile_index;
                    bowl_next       = item.bowl_number;
                    cmd             = fas_pkg::CMD_MOVE;
                    target          = item.bowl_position;
                    state_next      = fas_pkg::ST_OPEN;
                    entered_at_next = item.now_ms;
                end
            end
            fas_pkg::ST_OPEN:
            begin
                if (item.motor_arrived)
                begin
                    cmd                  = fas_pkg::CMD_DISABLE;
                    motor_good_next      = 1'b1;
                    start_weight_next    = item.weight_dg;
                    start_weight_ok_next = item.weight_ok;
                    state_next           = fas_pkg::ST_FEED;
                    entered_at_next      = item.now_ms;
                    meal_start_next      = item.now_ms;
                    absent_timing_next   = 1'b0;
                end
                else if (motor_expired)
                begin
                    cmd             = fas_pkg::CMD_DISABLE;
                    motor_good_next = 1'b0;
                    fault           = fas_pkg::FAULT_OPEN;
                    state_next      = fas_pkg::ST_IDLE;
                end
            end
            fas_pkg::ST_FEED:
            begin
                // absence timer: first absent pass arms, later ones check
                if (item.animal_present)
                begin
                    absent_timing_next = 1'b0;
                    close_now          = meal_expired;
                end
                else if (!absent_timing_reg)
                begin
                    absent_timing_next = 1'b1;
                    absent_since_next  = item.now_ms;
                    close_now          = meal_expired;
                end
                else
                begin
                    close_now = leave_expired || meal_expired;
                end
                if (close_now)
                begin
                    intake_next     = intake_calc;
                    intake_ok_next  = intake_calc_ok;
                    cmd             = fas_pkg::CMD_HOME;
                    state_next      = fas_pkg::ST_CLOSE;
                    entered_at_next = item.now_ms;
                end
            end
            fas_pkg::ST_CLOSE:
            begin
                if (item.motor_arrived)
                begin
                    cmd             = fas_pkg::CMD_DISABLE;
                    motor_good_next = 1'b1;
                    emit            = 1'b1;
                    state_next      = fas_pkg::ST_IDLE;
                end
                else if (motor_expired)
                begin
                    cmd             = fas_pkg::CMD_DISABLE;
                    motor_good_next = 1'b0;
                    fault           = fas_pkg::FAULT_CLOSE;
                    emit            = 1'b1;
                    state_next      = fas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fas_pkg::ST_IDLE;
            end
        endcase
    end

    // Phase code of the state after this pass
    always_comb
    begin
        unique case (state_next)
            fas_pkg::ST_IDLE:   phase_code = fas_pkg::PHASE_IDLE;
            fas_pkg::ST_DETECT: phase_code = fas_pkg::PHASE_DETECT;
            fas_pkg::ST_OPEN:   phase_code = fas_pkg::PHASE_OPEN;
            fas_pkg::ST_FEED:   phase_code = fas_pkg::PHASE_FEED;
            fas_pkg::ST_CLOSE:  phase_code = fas_pkg::PHASE_CLOSE;
            default:            phase_code = fas_pkg::PHASE_IDLE;
        endcase
    end

    // Result of this pass; the record fields read the stored meal
    always_comb
    begin
        result.phase            = phase_code;
        result.motor_command    = cmd;
        result.motor_target     = target;
        result.active_bowl      = bowl_next;
        result.fault_code       = fault;
        result.motor_healthy    = motor_good_next;
        result.record_emit      = emit;
        result.record_profile   = emit ? profile_reg : 4'd0;
        result.record_start_ms  = emit ? meal_start_reg : 32'd0;
        result.record_intake_dg = emit ? intake_reg : 17'd0;
        result.record_intake_ok = emit && intake_ok_reg;
    end

    // State update on each processed pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= fas_pkg::ST_IDLE;
            entered_at_reg      <= 32'd0;
            absent_since_reg    <= 32'd0;
            absent_timing_reg   <= 1'b0;
            profile_reg         <= 4'd0;
            bowl_reg            <= 2'd0;
            meal_start_reg      <= 32'd0;
            start_weight_reg    <= 18'sd0;
            start_weight_ok_reg <= 1'b0;
            intake_reg          <= 17'd0;
            intake_ok_reg       <= 1'b0;
            motor_good_reg      <= 1'b1;
        end
        else if (fire)
        begin
            state_reg           <= state_next;
            entered_at_reg      <= entered_at_next;
            absent_since_reg    <= absent_since_next;
            absent_timing_reg   <= absent_timing_next;
            profile_reg         <= profile_next;
            bowl_reg            <= bowl_next;
            meal_start_reg      <= meal_start_next;
            start_weight_reg    <= start_weight_next;
            start_weight_ok_reg <= start_weight_ok_next;
            intake_reg          <= intake_next;
            intake_ok_reg       <= intake_ok_next;
            motor_good_reg      <= motor_good_next;
        end
    end

endmodule
